>>> hw/rtl/mvfb_pkg.sv
// ----------------------------------------------------------------------------
// mvfb_pkg
// Types, constants and the CRC step shared by the motor velocity frame builder.
// ----------------------------------------------------------------------------
package mvfb_pkg;

   localparam int FRAME_LEN           = 10;
   localparam int CNT_W               = $clog2(FRAME_LEN);
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 15;

   localparam logic [14:0] SPEED_LIMIT_RESET = 15'd330;
   localparam logic [7:0]  ACCEL_TIME_RESET  = 8'h0A;
   localparam logic [7:0]  BRAKE_TIME_RESET  = 8'h00;

   localparam logic [7:0] CMD_VELOCITY = 8'h64;
   localparam logic [7:0] CRC_POLY     = 8'h8C;
   localparam logic [7:0] CRC_INIT     = 8'h00;
   localparam logic [7:0] PAD_BYTE     = 8'h00;

   // motors mounted the other way round
   localparam logic [7:0] MOTOR_REV_A = 8'd1;
   localparam logic [7:0] MOTOR_REV_B = 8'd3;

   localparam logic [CNT_W-1:0] LAST_POS = CNT_W'(FRAME_LEN - 1);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SPEED_LIMIT = 2'd0,
      CSR_ACCEL_TIME  = 2'd1,
      CSR_BRAKE_TIME  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [7:0]  drive_id;
      logic [15:0] speed_word;
      logic [7:0]  accel_time;
      logic [7:0]  brake_time;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } qstat_type;

   // one byte through the reflected crc-8, lsb first
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      c = crc ^ data;
      for (int b = 0; b < 8; b++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

>>> hw/rtl/mvfb_front.sv
// ----------------------------------------------------------------------------
// mvfb_front
// Holds the control registers, takes commands, clamps and orients the speed.
// ----------------------------------------------------------------------------
module mvfb_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [7:0]                          req_drive_id,
   input  logic signed [15:0]                  req_speed_rpm,
   input  logic                                csr_write_enable,
   input  logic [mvfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvfb_pkg::CSR_DATA_W-1:0]     csr_write_data,
   input  mvfb_pkg::qstat_type                 qstat,
   output logic                                push,
   output mvfb_pkg::entry_type                 push_entry
);
   import mvfb_pkg::*;

   logic [14:0] speed_limit_ff, speed_limit_in;
   logic [7:0]  accel_time_ff, accel_time_in;
   logic [7:0]  brake_time_ff, brake_time_in;

   logic signed [16:0] spd_ext, lim_pos, lim_neg, clamped, oriented;

   always_comb begin
      speed_limit_in = speed_limit_ff;
      accel_time_in  = accel_time_ff;
      brake_time_in  = brake_time_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SPEED_LIMIT: speed_limit_in = csr_write_data[14:0];
            CSR_ACCEL_TIME:  accel_time_in  = csr_write_data[7:0];
            CSR_BRAKE_TIME:  brake_time_in  = csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_limit_ff <= SPEED_LIMIT_RESET;
         accel_time_ff  <= ACCEL_TIME_RESET;
         brake_time_ff  <= BRAKE_TIME_RESET;
      end else begin
         speed_limit_ff <= speed_limit_in;
         accel_time_ff  <= accel_time_in;
         brake_time_ff  <= brake_time_in;
      end
   end

   always_comb begin
      spd_ext = {req_speed_rpm[15], req_speed_rpm};
      lim_pos = {2'b00, speed_limit_ff};
      lim_neg = -lim_pos;
      priority if (spd_ext > lim_pos) begin
         clamped = lim_pos;
      end else if (spd_ext < lim_neg) begin
         clamped = lim_neg;
      end else begin
         clamped = spd_ext;
      end
      // clamped magnitude stays within 15 bits, so negation cannot overflow
      if (req_drive_id == MOTOR_REV_A || req_drive_id == MOTOR_REV_B) begin
         oriented = -clamped;
      end else begin
         oriented = clamped;
      end
   end

   assign push                  = start && !qstat.full;
   assign push_entry.drive_id   = req_drive_id;
   assign push_entry.speed_word = oriented[15:0];
   assign push_entry.accel_time = accel_time_ff;
   assign push_entry.brake_time = brake_time_ff;

endmodule

>>> hw/rtl/mvfb_queue.sv
// ----------------------------------------------------------------------------
// mvfb_queue
// Short command queue between the front and the frame serializer.
// ----------------------------------------------------------------------------
module mvfb_queue #(
   parameter int DEPTH = mvfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mvfb_pkg::entry_type push_entry,
   input  logic                pop,
   output mvfb_pkg::entry_type head,
   output mvfb_pkg::qstat_type qstat
);
   import mvfb_pkg::*;

   localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_W = $clog2(DEPTH + 1);

   entry_type slot_ff [DEPTH];

   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic do_push, do_pop;

   assign qstat.empty = (count_ff == '0);
   assign qstat.full  = (count_ff == COUNT_W'(DEPTH));
   assign do_push     = push && !qstat.full;
   assign do_pop      = pop && !qstat.empty;
   assign head        = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

>>> hw/rtl/mvfb_back.sv
// ----------------------------------------------------------------------------
// mvfb_back
// Frame serializer: one frame byte per cycle with a running crc-8.
// ----------------------------------------------------------------------------
module mvfb_back (
   input  logic                clock,
   input  logic                reset,
   input  mvfb_pkg::entry_type head,
   input  mvfb_pkg::qstat_type qstat,
   output logic                pop,
   output logic                rsp_valid,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_frame_last
);
   import mvfb_pkg::*;

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       crc_ff, crc_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic [7:0] frame_bytes [FRAME_LEN];
   logic       active, at_last;

   always_comb begin
      frame_bytes[0] = head.drive_id;
      frame_bytes[1] = CMD_VELOCITY;
      frame_bytes[2] = head.speed_word[15:8];
      frame_bytes[3] = head.speed_word[7:0];
      frame_bytes[4] = PAD_BYTE;
      frame_bytes[5] = PAD_BYTE;
      frame_bytes[6] = head.accel_time;
      frame_bytes[7] = head.brake_time;
      frame_bytes[8] = PAD_BYTE;
      frame_bytes[9] = crc_ff;
   end

   assign active  = !qstat.empty;
   assign at_last = (cnt_ff == LAST_POS);
   assign pop     = active && at_last;

   always_comb begin
      cnt_in   = cnt_ff;
      byte_in  = frame_bytes[cnt_ff];
      valid_in = active;
      last_in  = active && at_last;
      // crc restarts on the id byte
      crc_in   = crc8_byte((cnt_ff == '0) ? CRC_INIT : crc_ff, frame_bytes[cnt_ff]);
      if (active) begin
         cnt_in = at_last ? '0 : cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
         last_ff  <= 1'b0;
      end else begin
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
         last_ff  <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      crc_ff  <= crc_in;
      byte_ff <= byte_in;
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_last = last_ff;

endmodule

>>> hw/rtl/motor_velocity_frame_builder.sv
// When the serializer is free, a taken start passes the queue count register and
// then the output register; the ten bytes of its frame follow back to back.
// The byte-wide serializer pops a command only with the last byte of its frame.
// A queue of QUEUE_DEPTH commands sits ahead of it; busy is high while full.
// Reset clears the queue and output strobe and loads the register defaults.
// ----------------------------------------------------------------------------
// motor_velocity_frame_builder
// Builds 10-byte velocity command frames with a crc-8 trailer.
// ----------------------------------------------------------------------------
module motor_velocity_frame_builder #(
   parameter int QUEUE_DEPTH = mvfb_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [7:0]                       req_drive_id,
   input  logic signed [15:0]               req_speed_rpm,
   output logic                             rsp_valid,
   output logic [7:0]                       rsp_frame_byte,
   output logic                             rsp_frame_last,
   input  logic                             csr_write_enable,
   input  logic [mvfb_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [mvfb_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import mvfb_pkg::*;

   logic      push, pop;
   entry_type push_entry, head;
   qstat_type qstat;

   mvfb_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_drive_id     (req_drive_id),
      .req_speed_rpm    (req_speed_rpm),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .qstat            (qstat),
      .push             (push),
      .push_entry       (push_entry)
   );

   mvfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .qstat      (qstat)
   );

   mvfb_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head           (head),
      .qstat          (qstat),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

   assign busy = qstat.full;

endmodule

>>> hw/rtl/mvfb_checker.sv
// ----------------------------------------------------------------------------
// mvfb_checker
// Port-level checks on frame output timing, bound to the frame builder.
// ----------------------------------------------------------------------------
module mvfb_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_valid,
   input logic rsp_frame_last
);

   // queue and output strobe come up empty out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid && !busy)
      else $error("outputs not idle after reset");

   assert property (@(posedge clock) disable iff (reset) rsp_frame_last |-> rsp_valid)
      else $error("last marker without a byte");

   // frame bytes come out without gaps
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_frame_last |=> rsp_valid)
      else $error("gap inside a frame");

   assert property (@(posedge clock) disable iff (reset)
      rsp_frame_last |=> !rsp_frame_last)
      else $error("back to back last markers");

   // nothing comes out of an empty block
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && !busy && !start |=> !rsp_valid || $past(rsp_valid, 2)
         || $past(start, 2))
      else $error("frame byte with no command");

endmodule

bind motor_velocity_frame_builder mvfb_checker u_checker (.*);
